// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by modular_inverse.sv. They compile to
// nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/mi_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular inverse package
// Field widths, default datapath width and transaction payload types.
// ----------------------------------------------------------------------------
package mi_pkg;

    localparam int FIELD_W   = 32;
    localparam int WIDTH_DEF = 32;

    typedef struct packed {
        logic [FIELD_W-1:0] value;
        logic [FIELD_W-1:0] modulus;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] inverse;
        logic               no_inverse;
    } t_out_item;

endpackage

// ===== design/mi_stream_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One transaction moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface mi_stream_if #(
    parameter type t_payload = logic
) ();

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ===== design/modular_inverse.sv =====
// ----------------------------------------------------------------------------
// Modular inverse
// Extended Euclidean inverse of a value modulo a modulus, one transaction in,
// one transaction out.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time: ready is high only while it is
// idle. Each Euclid step runs through one shared shift-subtract unit that does
// one subtract and one add per cycle: the divisor is first doubled until it
// would pass the remainder, then walked back down, subtracting and
// accumulating the coefficient. A modulus below 2 skips the Euclid steps and
// is answered with no inverse. The result register lets a new transaction be
// accepted while the previous result still waits to be taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module modular_inverse #(
    parameter int WIDTH = mi_pkg::WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mi_stream_if.sink   i_in,
    mi_stream_if.source o_out
);

    import mi_pkg::*;

    localparam int KW = $clog2(WIDTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ALIGN = 2'd1;
    localparam logic [1:0] S_SUB   = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]       r_state, n_state;
    logic             r_out_valid;
    t_out_item        r_out;

    // Euclid state: remainders and coefficient magnitudes.
    logic [WIDTH-1:0] r_rp, r_rc, r_up, r_uc, r_mod;
    // Working registers of the shift-subtract unit.
    logic [WIDTH-1:0] r_rem, r_ds, r_us, r_acc;
    logic [KW-1:0]    r_k;
    logic             r_first, r_knz, r_kodd;

    logic [WIDTH-1:0] w_a, w_m;
    logic             w_in_acc, w_out_free, w_small;
    logic             w_grow, w_fits, w_neg, w_none;
    logic [WIDTH:0]   w_diff;
    logic [WIDTH-1:0] w_rem_new, w_acc_new, w_inv;

    assign w_a      = WIDTH'(i_in.payload.value);
    assign w_m      = WIDTH'(i_in.payload.modulus);
    assign w_small  = w_m < WIDTH'(2);

    assign i_in.ready    = (r_state == S_IDLE);
    assign w_in_acc      = i_in.valid && i_in.ready;
    assign w_out_free    = !r_out_valid || o_out.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // Doubling stops once twice the divisor would exceed the remainder.
    assign w_grow    = {r_ds, 1'b0} <= {1'b0, r_rem};
    assign w_diff    = {1'b0, r_rem} - {1'b0, r_ds};
    assign w_fits    = !w_diff[WIDTH];
    assign w_rem_new = w_fits ? w_diff[WIDTH-1:0] : r_rem;
    assign w_acc_new = w_fits ? (r_acc + r_us) : r_acc;

    // The final coefficient is negative for an even, nonzero step count.
    assign w_neg  = r_knz && !r_kodd;
    assign w_none = (r_rp != WIDTH'(1));
    assign w_inv  = w_none ? '0 : (w_neg ? (r_mod - r_up) : r_up);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_small ? S_FIN : S_ALIGN;
                end
            end
            S_ALIGN: begin
                if (!w_grow) begin
                    n_state = S_SUB;
                end
            end
            S_SUB: begin
                if (r_k == '0) begin
                    n_state = (w_rem_new == '0) ? S_FIN : S_ALIGN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_mod   <= w_m;
                    r_first <= 1'b1;
                    r_knz   <= 1'b0;
                    r_kodd  <= 1'b0;
                    if (w_small) begin
                        r_rp <= '0;
                    end else begin
                        // The first step divides the value by the modulus,
                        // which reduces it and sets up the coefficients 0 and 1.
                        r_rp  <= w_a;
                        r_rc  <= w_m;
                        r_up  <= WIDTH'(1);
                        r_uc  <= '0;
                        r_rem <= w_a;
                        r_ds  <= w_m;
                        r_us  <= '0;
                        r_acc <= WIDTH'(1);
                        r_k   <= '0;
                    end
                end
            end
            S_ALIGN: begin
                if (w_grow) begin
                    r_ds <= r_ds << 1;
                    r_us <= r_us << 1;
                    r_k  <= r_k + KW'(1);
                end
            end
            S_SUB: begin
                if (r_k != '0) begin
                    r_rem <= w_rem_new;
                    r_acc <= w_acc_new;
                    r_ds  <= r_ds >> 1;
                    r_us  <= r_us >> 1;
                    r_k   <= r_k - KW'(1);
                end else begin
                    r_rp  <= r_rc;
                    r_rc  <= w_rem_new;
                    r_up  <= r_uc;
                    r_uc  <= w_acc_new;
                    // Load the next step straight away.
                    r_rem <= r_rc;
                    r_ds  <= w_rem_new;
                    r_acc <= r_uc;
                    r_us  <= w_acc_new;
                    if (r_first) begin
                        r_first <= 1'b0;
                    end else begin
                        r_knz  <= 1'b1;
                        r_kodd <= !r_kodd;
                    end
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    r_out.inverse    <= FIELD_W'(w_inv);
                    r_out.no_inverse <= w_none;
                end
            end
            default: ;
        endcase
    end

    `ASSERT_IMPLIES(a_inverse_nonzero, i_clk, i_rst_n, r_out_valid && !r_out.no_inverse, r_out.inverse != '0)
    `ASSERT_IMPLIES(a_none_zero, i_clk, i_rst_n, r_out_valid && r_out.no_inverse, r_out.inverse == '0)
    `ASSERT_IMPLIES(a_divisor_nonzero, i_clk, i_rst_n, r_state == S_SUB, r_ds != '0)
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, r_state != S_IDLE)

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse testbench
// Drives value/modulus transactions into the block and compares every result
// with an extended Euclid prediction computed here. A directed set covers the
// corner cases, then random operands follow in three phases: heavy sink
// back-pressure, light sink back-pressure with an idle source, and none.
module tb_top;

    import mi_pkg::*;

    localparam int WIDTH         = WIDTH_DEF;
    localparam int LATENCY_MAX   = 4 * WIDTH + 4;
    localparam int ITEMS_RANDOM  = 900;
    localparam logic [31:0] ALL1 = 32'hFFFF_FFFF;

    // Holds the inverses still owed by the block, oldest first.
    class inverse_scoreboard;
        t_out_item owed_q[$];
        int        n_inputs;
        int        n_checked;
        int        n_no_inverse;
        int        n_mismatch;

        function t_out_item predict_inverse(logic [31:0] v, logic [31:0] m);
            logic [63:0] r_old, r_new, r_tmp, u_old, u_new, u_tmp, q;
            int unsigned steps;
            t_out_item   res;
            res.inverse    = '0;
            res.no_inverse = 1'b1;
            if (m < 2) return res;
            r_old = {32'h0, m};
            r_new = {32'h0, v} % {32'h0, m};
            u_old = 64'd0;
            u_new = 64'd1;
            steps = 0;
            while (r_new != 0) begin
                q     = r_old / r_new;
                r_tmp = r_old - q * r_new;
                u_tmp = u_old + q * u_new;
                r_old = r_new;
                r_new = r_tmp;
                u_old = u_new;
                u_new = u_tmp;
                steps++;
            end
            if (r_old != 1) return res;
            res.no_inverse = 1'b0;
            // Coefficient signs alternate: positive after an odd number of steps.
            if (steps != 0 && steps[0] == 1'b0)
                res.inverse = m - u_old[31:0];
            else
                res.inverse = u_old[31:0];
            return res;
        endfunction

        function void note_operands(t_in_item it);
            owed_q.push_back(predict_inverse(it.value, it.modulus));
            n_inputs++;
        endfunction

        task report_mismatch(string what);
            n_mismatch++;
            $display("[%0t] mismatch %0d: %s", $time, n_mismatch, what);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (owed_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result inverse=%0h no_inverse=%0b",
                                          got.inverse, got.no_inverse));
                return;
            end
            want = owed_q.pop_front();
            n_checked++;
            if (want.no_inverse) n_no_inverse++;
            if (got.inverse !== want.inverse)
                report_mismatch($sformatf("inverse got %0h want %0h",
                                          got.inverse, want.inverse));
            if (got.no_inverse !== want.no_inverse)
                report_mismatch($sformatf("no_inverse got %0b want %0b",
                                          got.no_inverse, want.no_inverse));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;

    inverse_scoreboard sb = new();

    mi_stream_if #(.t_payload(t_in_item))  in_if ();
    mi_stream_if #(.t_payload(t_out_item)) out_if ();

    modular_inverse #(.WIDTH(WIDTH)) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) begin
        out_if.ready <= rst_n && ($urandom_range(99, 0) >= sink_idle_pct);
    end

    // Both monitors sample at the edge, before any flop of this step updates.
    always @(posedge clk) begin
        if (rst_n && in_if.valid && in_if.ready) sb.note_operands(in_if.payload);
    end

    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.payload);
    end

    task automatic send_operands(input logic [31:0] v, input logic [31:0] m);
        t_in_item it;
        it.value   = v;
        it.modulus = m;
        if ($urandom_range(99, 0) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99, 0) < src_idle_pct);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= it;
        do @(posedge clk); while (!in_if.ready);
    endtask

    task automatic pick_operands(output logic [31:0] v, output logic [31:0] m);
        int unsigned kind, g;
        kind = $urandom_range(99, 0);
        if (kind < 35) begin
            v = $urandom();
            m = $urandom();
        end else if (kind < 55) begin
            // Key-setup shape: small public exponent against an even totient.
            case ($urandom_range(3, 0))
                0: v = 32'd3;
                1: v = 32'd17;
                2: v = 32'd65537;
                default: v = $urandom() | 32'h1;
            endcase
            m = $urandom() & ~32'h1;
        end else if (kind < 70) begin
            v = $urandom();
            m = $urandom_range(1000, 2);
        end else if (kind < 80) begin
            m = $urandom_range(ALL1, 2);
            case ($urandom_range(2, 0))
                0: v = m + 1;
                1: v = m - 1;
                default: v = m - $urandom_range(3, 2);
            endcase
        end else if (kind < 92) begin
            g = $urandom_range(65535, 2);
            v = g * $urandom_range(ALL1 / g, 1);
            m = g * $urandom_range(ALL1 / g, 1);
        end else begin
            v = ($urandom_range(1, 0) == 0) ? 32'd0 : $urandom();
            m = $urandom_range(3, 0);
        end
    endtask

    task automatic run_random(input int count);
        logic [31:0] v, m;
        repeat (count) begin
            pick_operands(v, m);
            send_operands(v, m);
        end
    endtask

    initial begin
        int wait_cycles;
        in_if.valid   <= 1'b0;
        in_if.payload <= '0;
        rst_n         <= 1'b0;
        src_idle_pct  = 23;
        sink_idle_pct = 62;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_operands(32'd1, 32'd2);
        send_operands(32'd1, ALL1);
        send_operands(ALL1, ALL1);                     // multiple of the modulus
        send_operands(32'd0, 32'd5);                   // zero value
        send_operands(32'd5, 32'd0);                   // zero modulus
        send_operands(32'd7, 32'd1);                   // modulus of one
        send_operands(32'd0, 32'd0);
        send_operands(ALL1, ALL1 - 1);                 // congruent to one
        send_operands(ALL1 - 1, ALL1);                 // minus one
        send_operands(32'd13, 32'd12);                 // reduced first
        send_operands(32'd24, 32'd12);
        send_operands(32'd2, 32'd4);
        send_operands(32'd6, 32'd9);
        send_operands(32'd65537, 32'd3120);
        send_operands(32'd2971215073, 32'd1836311903); // longest quotient chain
        send_operands(32'd1836311903, 32'd2971215073);
        send_operands(32'h8000_0000, 32'h7FFF_FFFF);
        send_operands(32'd3, 32'h8000_0000);
        send_operands(ALL1, 32'h8000_0000);
        send_operands(32'h5555_5555, 32'hAAAA_AAAA);
        send_operands(32'd2, ALL1);

        run_random(ITEMS_RANDOM / 3);
        src_idle_pct  = 62;
        sink_idle_pct = 23;
        run_random(ITEMS_RANDOM / 3);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random(ITEMS_RANDOM / 3);
        in_if.valid <= 1'b0;

        wait_cycles = 0;
        while (sb.owed_q.size() != 0 && wait_cycles < 100 * LATENCY_MAX) begin
            @(posedge clk);
            wait_cycles++;
        end
        if (sb.owed_q.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.owed_q.size()));
        repeat (LATENCY_MAX + 8) @(posedge clk);

        $display("Run covered %0d operand pairs and %0d checked results.",
                 sb.n_inputs, sb.n_checked);
        $display("%0d of them had no inverse; %0d mismatches seen.",
                 sb.n_no_inverse, sb.n_mismatch);
        if (sb.n_mismatch == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Simulation time limit reached.");
        $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/mi_pkg.sv
design/mi_stream_if.sv
design/modular_inverse.sv
dv/tb_top.sv
